// ----- hdl/sort_and_merge_two_arrays_top_macros.svh -----
// ----------------------------------------------------------------------------
// sort_and_merge_two_arrays_top_macros
// assertion macros for the checker file samta_chk
// ----------------------------------------------------------------------------
`ifndef SORT_AND_MERGE_TWO_ARRAYS_TOP_MACROS_SVH
`define SORT_AND_MERGE_TWO_ARRAYS_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAMTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SAMTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/samta_pkg.sv -----
// ----------------------------------------------------------------------------
// samta_pkg
// widths, types and command/status structs of the sort and merge block
// ----------------------------------------------------------------------------
`default_nettype none

package samta_pkg;

  localparam int ARRAY_LEN = 5;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = $clog2(ARRAY_LEN + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // store the presented word
    logic pop;    // move the next merged word into the output register
  } samta_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic completes;  // presented word fills the last free place of both sets
    logic last_word;  // exactly one element left to merge
  } samta_status_t;

endpackage

`default_nettype wire

// ----- hdl/samta_ctrl.sv -----
// ----------------------------------------------------------------------------
// samta_ctrl
// load/merge sequencer and output valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module samta_ctrl
  import samta_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load_valid,
  output logic          load_stall,
  output logic          merge_valid,
  input  logic          merge_stall,
  input  samta_status_t status,
  output samta_cmd_t    cmd
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;

  always_comb begin
    load_stall = (state == ST_MERGE);
    cmd.load   = load_valid && (state == ST_LOAD);
    cmd.pop    = (state == ST_MERGE) && (!out_valid || !merge_stall);
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (cmd.load && status.completes) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (cmd.pop && status.last_word) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
    if (cmd.pop) begin
      out_valid_next = 1'b1;
    end else if (!merge_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign merge_valid = out_valid;

endmodule

`default_nettype wire

// ----- hdl/samta_dp.sv -----
// ----------------------------------------------------------------------------
// samta_dp
// two sorted cell rows with insert-on-load, head-pop merge, output register
// ----------------------------------------------------------------------------
`default_nettype none

module samta_dp
  import samta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  samta_cmd_t               cmd,
  output samta_status_t            status,
  input  logic                     set_select,
  input  logic signed [WORD_W-1:0] value,
  output logic signed [WORD_W-1:0] merged_value,
  output logic                     last
);

  typedef word_t [ARRAY_LEN-1:0] set_t;

  // insert into an ascending row holding n valid cells
  function automatic set_t insert_sorted(set_t s, cnt_t n, word_t v);
    set_t                 r;
    logic [ARRAY_LEN-1:0] ge;
    for (int k = 0; k < ARRAY_LEN; k++) begin
      ge[k] = (CNT_W'(k) < n) && !($signed(v) < $signed(s[k]));
    end
    r[0] = ge[0] ? s[0] : v;
    for (int k = 1; k < ARRAY_LEN; k++) begin
      if (ge[k]) begin
        r[k] = s[k];
      end else if (ge[k-1]) begin
        r[k] = v;
      end else begin
        r[k] = s[k-1];
      end
    end
    return r;
  endfunction

  // drop the head cell
  function automatic set_t shift_out(set_t s);
    set_t r;
    for (int k = 0; k < ARRAY_LEN - 1; k++) begin
      r[k] = s[k+1];
    end
    r[ARRAY_LEN-1] = s[ARRAY_LEN-1];
    return r;
  endfunction

  set_t  set_a;
  set_t  set_b;
  cnt_t  cnt_a;
  cnt_t  cnt_b;
  word_t out_word;
  logic  out_last;
  logic  take_a;
  logic  a_full;
  logic  b_full;

  always_comb begin
    a_full = (cnt_a == CNT_W'(ARRAY_LEN));
    b_full = (cnt_b == CNT_W'(ARRAY_LEN));
    status.completes = set_select ? (b_full == 1'b0 && cnt_b == CNT_W'(ARRAY_LEN - 1) && a_full)
                                  : (a_full == 1'b0 && cnt_a == CNT_W'(ARRAY_LEN - 1) && b_full);
    status.last_word = (({1'b0, cnt_a} + {1'b0, cnt_b}) == (CNT_W + 1)'(1));
    // ties go to the second set
    take_a = (cnt_a != '0) &&
             ((cnt_b == '0) || ($signed(set_a[0]) < $signed(set_b[0])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (cmd.load) begin
      if (!set_select && !a_full) begin
        cnt_a <= cnt_a + CNT_W'(1);
      end else if (set_select && !b_full) begin
        cnt_b <= cnt_b + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      if (take_a) begin
        cnt_a <= cnt_a - CNT_W'(1);
      end else begin
        cnt_b <= cnt_b - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (!set_select && !a_full) begin
        set_a <= insert_sorted(set_a, cnt_a, word_t'(value));
      end else if (set_select && !b_full) begin
        set_b <= insert_sorted(set_b, cnt_b, word_t'(value));
      end
    end else if (cmd.pop) begin
      out_last <= status.last_word;
      if (take_a) begin
        out_word <= set_a[0];
        set_a    <= shift_out(set_a);
      end else begin
        out_word <= set_b[0];
        set_b    <= shift_out(set_b);
      end
    end
  end

  assign merged_value = $signed(out_word);
  assign last         = out_last;

endmodule

`default_nettype wire

// ----- hdl/sort_and_merge_two_arrays_top.sv -----
// ----------------------------------------------------------------------------
// sort_and_merge_two_arrays_top
// loads two sets of signed words, sorts each ascending, streams the merge
// ----------------------------------------------------------------------------
//
//   channel  handshake                  fields
//   -------  -------------------------  ------------------------------------
//   load     load_valid / load_stall    set_select[0], value[31:0] signed
//   merge    merge_valid / merge_stall  merged_value[31:0] signed, last
//
// a load word is insertion-sorted into its set row as it is stored, so the
// sets are always in ascending order
// the word that fills both sets starts the merge: 2*ARRAY_LEN words leave at
// one per cycle while merge_stall is low, set by the single head compare; load_stall is high meanwhile
// a load word for a set that is already full is taken and dropped
// synchronous reset clears the counts, the sequencer and merge_valid; the
// set cells are not cleared
// a stall on the merge side holds the output register and the merge with it
//
`default_nettype none

module sort_and_merge_two_arrays_top
  import samta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // load channel
  input  logic                     load_valid,
  output logic                     load_stall,
  input  logic                     set_select,
  input  logic signed [WORD_W-1:0] value,
  // merge channel
  output logic                     merge_valid,
  input  logic                     merge_stall,
  output logic signed [WORD_W-1:0] merged_value,
  output logic                     last
);

  samta_cmd_t    cmd;
  samta_status_t status;

  // sequencer: load phase, merge phase, output valid flag
  samta_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (load_valid),
    .load_stall  (load_stall),
    .merge_valid (merge_valid),
    .merge_stall (merge_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // sorted set rows, counts and the output word register
  samta_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .set_select   (set_select),
    .value        (value),
    .merged_value (merged_value),
    .last         (last)
  );

endmodule

`default_nettype wire

// ----- hdl/samta_chk.sv -----
// ----------------------------------------------------------------------------
// samta_chk
// port-level checks of the sort and merge block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sort_and_merge_two_arrays_top_macros.svh"

module samta_chk
  import samta_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     load_valid,
  input logic                     load_stall,
  input logic                     set_select,
  input logic signed [WORD_W-1:0] value,
  input logic                     merge_valid,
  input logic                     merge_stall,
  input logic signed [WORD_W-1:0] merged_value,
  input logic                     last
);

  // stalled output word holds
  `SAMTA_ASSERT_NEXT(a_hold, clk, rst, merge_valid && merge_stall, merge_valid && $stable(merged_value) && $stable(last), "stalled merge word changed")

  // a word before the last one means the merge is still running
  `SAMTA_ASSERT_NOW(a_mid_merge, clk, rst, merge_valid && !last, load_stall, "load open during merge")

  // loading reopens only with the last word in the output register
  `SAMTA_ASSERT_NOW(a_reopen, clk, rst, $fell(load_stall), merge_valid && last, "load reopened without last word")

endmodule

bind sort_and_merge_two_arrays_top samta_chk u_samta_chk (.*);

`default_nettype wire

// ----- verif/sort_and_merge_two_arrays_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_and_merge_two_arrays_top_test
// self-checking bench for the two-set sort and merge block
//
// loads of five words per set go in over the load channel with bursts and
// gaps. A local model sorts both sets and merges them, and every word on
// the merge channel is checked in order against it. The receiver stalls at
// random, on a fixed pattern, or holds off for a long stretch. Words for a
// set that is already full are also sent; the block must drop them.
// ----------------------------------------------------------------------------
`default_nettype none

module sort_and_merge_two_arrays_top_test;
  import samta_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_PAD    = 20;      // quiet cycles after the last merged word
  localparam int RANDOM_WORDS = 380;     // stored words in the random phase
  localparam int PRINT_CAP    = 50;      // mismatch lines printed at most

  localparam logic signed [WORD_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] MOST_POS = 32'sh7fff_ffff;

  // receiver stall behaviors
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  // one expected word of the merge channel
  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     lst;
  } merge_word_t;

  // dut ports, all inputs known from time zero
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     load_valid = 1'b0;
  logic                     load_stall;
  logic                     set_select = 1'b0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     merge_valid;
  logic                     merge_stall = 1'b0;
  logic signed [WORD_W-1:0] merged_value;
  logic                     last;

  // local model of the two sets
  logic signed [WORD_W-1:0] set_vals [2][ARRAY_LEN];
  int                       set_fill [2];
  merge_word_t              merge_expect [$];

  // run bookkeeping
  int          mismatches     = 0;
  int          stored_words   = 0;
  int          dropped_words  = 0;
  int          loads_done     = 0;
  int          words_checked  = 0;
  int          cycle_count    = 0;

  // sender and receiver pacing
  bit          gaps_on    = 1'b0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          hold_len   = 0;
  int          hold_req   = 0;
  int          hold_ack   = 0;
  int          hold_left  = 0;
  int          stall_phase = 0;

  merge_word_t head_word;

  sort_and_merge_two_arrays_top dut (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .set_select   (set_select),
    .value        (value),
    .merge_valid  (merge_valid),
    .merge_stall  (merge_stall),
    .merged_value (merged_value),
    .last         (last)
  );

  always #10 clk = ~clk;

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d merged words still expected",
               cycle_count, merge_expect.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one line per mismatch, the count goes on past the print cap
  task automatic report_mismatch(input string what, input longint exp_v,
                                 input longint got_v);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s expected %0d got %0d",
               cycle_count, what, exp_v, got_v);
    mismatches++;
  endtask

  // model: store one word, and on the word that fills both sets sort them
  // and queue the whole merged sequence
  task automatic store_and_merge(input logic sel, input logic signed [WORD_W-1:0] v);
    int                       ia;
    int                       ib;
    logic signed [WORD_W-1:0] swap;
    merge_word_t              w;
    // a full set drops the word
    if (set_fill[sel] >= ARRAY_LEN) begin
      dropped_words++;
      return;
    end
    set_vals[sel][set_fill[sel]] = v;
    set_fill[sel]++;
    stored_words++;
    if (set_fill[0] < ARRAY_LEN || set_fill[1] < ARRAY_LEN)
      return;
    // exchange sort of each set, ascending, signed
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < ARRAY_LEN; i++)
        for (int j = i + 1; j < ARRAY_LEN; j++)
          if (set_vals[s][j] < set_vals[s][i]) begin
            swap           = set_vals[s][i];
            set_vals[s][i] = set_vals[s][j];
            set_vals[s][j] = swap;
          end
    // two-way merge, ties go to the second set, a used-up set yields the rest
    ia = 0;
    ib = 0;
    for (int k = 0; k < 2 * ARRAY_LEN; k++) begin
      if (ia < ARRAY_LEN && (ib >= ARRAY_LEN || set_vals[0][ia] < set_vals[1][ib])) begin
        w.val = set_vals[0][ia];
        ia++;
      end else begin
        w.val = set_vals[1][ib];
        ib++;
      end
      w.lst = (k == 2 * ARRAY_LEN - 1);
      merge_expect.push_back(w);
    end
    set_fill[0] = 0;
    set_fill[1] = 0;
    loads_done++;
  endtask

  // sender gap: valid held low and payload scrambled for the requested gap
  task automatic idle_cycles(input int n);
    @(negedge clk);
    load_valid <= 1'b0;
    value      <= $urandom;
    set_select <= $urandom_range(0, 1);
    repeat (n - 1) @(negedge clk);
  endtask

  // offer one word and wait for the handshake; bursts and gaps follow
  task automatic send_word(input logic sel, input logic signed [WORD_W-1:0] v);
    @(negedge clk);
    load_valid <= 1'b1;
    set_select <= sel;
    value      <= v;
    @(posedge clk);
    while (load_stall) @(posedge clk);
    store_and_merge(sel, v);
    if (gaps_on) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 6));
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // lower valid, then wait for the last merged word and a quiet stretch
  task automatic wait_merge_done();
    @(negedge clk);
    load_valid <= 1'b0;
    while (merge_expect.size() > 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // value mix: full range, tight range for ties, extremes, values just above the most negative
  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return $urandom;
    else if (r < 7)
      return $signed($urandom_range(0, 8)) - 4;
    else if (r < 9)
      return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
    else
      return MOST_NEG + $urandom_range(0, 3);
  endfunction

  // one load in random interleaved order, optionally with words for a set
  // that is already full
  task automatic send_random_load(input bit with_strays);
    logic order [2 * ARRAY_LEN];
    logic tmp;
    int   pick;
    int   fill0;
    int   fill1;
    for (int k = 0; k < 2 * ARRAY_LEN; k++)
      order[k] = (k >= ARRAY_LEN);
    for (int k = 2 * ARRAY_LEN - 1; k > 0; k--) begin
      pick        = $urandom_range(0, k);
      tmp         = order[k];
      order[k]    = order[pick];
      order[pick] = tmp;
    end
    fill0 = 0;
    fill1 = 0;
    for (int k = 0; k < 2 * ARRAY_LEN; k++) begin
      send_word(order[k], pick_value());
      if (order[k]) fill1++;
      else fill0++;
      // stray word for the full set while the other one still loads
      if (with_strays && k < 2 * ARRAY_LEN - 1 && $urandom_range(0, 99) < 40) begin
        if (fill0 == ARRAY_LEN) send_word(1'b0, pick_value());
        else if (fill1 == ARRAY_LEN) send_word(1'b1, pick_value());
      end
    end
  endtask

  // every value appears in both sets, so each value meets a tie in the merge
  task automatic test_tied_extremes();
    logic signed [WORD_W-1:0] vals [ARRAY_LEN];
    vals = '{MOST_POS, MOST_NEG, 0, -1, 1};
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    for (int i = 0; i < ARRAY_LEN; i++) begin
      send_word(1'b0, vals[i]);
      send_word(1'b1, vals[ARRAY_LEN - 1 - i]);
    end
    wait_merge_done();
  endtask

  // first set filled in descending order, two extra words dropped, then a
  // second set that is all larger so the first set runs out early
  task automatic test_full_set_dropped();
    stall_mode = STALL_PATTERN;
    gaps_on    = 1'b1;
    for (int i = 0; i < ARRAY_LEN; i++)
      send_word(1'b0, MOST_NEG + ARRAY_LEN - 1 - i);
    send_word(1'b0, MOST_POS);
    send_word(1'b0, -7);
    for (int i = 0; i < ARRAY_LEN; i++)
      send_word(1'b1, MOST_POS - i);
    wait_merge_done();
  endtask

  // long receiver hold-off while the sender keeps offering whole loads
  task automatic test_output_hold_off();
    stall_mode = STALL_NONE;
    gaps_on    = 1'b0;
    hold_len   = 150;
    hold_req++;
    repeat (3) send_random_load(1'b0);
    wait_merge_done();
  endtask

  // random loads under mixed pacing; some stretches run with no idling
  task automatic test_random_loads();
    int target;
    target = stored_words + RANDOM_WORDS;
    while (stored_words < target) begin
      if ($urandom_range(0, 5) == 0) begin
        stall_mode = STALL_NONE;
        gaps_on    = 1'b0;
      end else begin
        stall_mode = stall_mode_t'($urandom_range(0, 2));
        gaps_on    = $urandom_range(0, 3) != 0;
      end
      send_random_load($urandom_range(0, 99) < 25);
    end
    wait_merge_done();
  endtask

  // receiver side: hold-off first, then the chosen stall behavior
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 7;
    if (rst) begin
      merge_stall <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = hold_len - 1;
      merge_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      merge_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  merge_stall <= $urandom_range(0, 99) < 35;
        STALL_PATTERN: merge_stall <= stall_phase < 3;
        default:       merge_stall <= 1'b0;
      endcase
    end
  end

  // every accepted merged word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && merge_valid && !merge_stall) begin
      if (merge_expect.size() == 0) begin
        report_mismatch("merged word with nothing expected, value", 0, merged_value);
      end else begin
        head_word = merge_expect.pop_front();
        words_checked++;
        if (merged_value !== head_word.val)
          report_mismatch("merged_value", head_word.val, merged_value);
        if (last !== head_word.lst)
          report_mismatch("last", head_word.lst, last);
      end
    end
  end

  initial begin
    set_fill[0] = 0;
    set_fill[1] = 0;
    // reset held, then released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_tied_extremes();
    test_full_set_dropped();
    test_output_hold_off();
    test_random_loads();

    if (merge_expect.size() != 0)
      report_mismatch("merged words left over, count", 0, merge_expect.size());
    $display("covered %0d loads and %0d checked merged words", loads_done, words_checked);
    $display("%0d words stored, %0d words for a full set dropped",
             stored_words, dropped_words);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/samta_pkg.sv
hdl/samta_ctrl.sv
hdl/samta_dp.sv
hdl/sort_and_merge_two_arrays_top.sv
hdl/samta_chk.sv
verif/sort_and_merge_two_arrays_top_test.sv
